@@ src/rws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_pkg
// Types and fixed constants shared by the rolling window skewness block.
// ----------------------------------------------------------------------------
package rws_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_SQRT,
        ST_ABS,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_D2,
        OP_O2,
        OP_D3,
        OP_O3,
        OP_Q,
        OP_NN,
        OP_S2A,
        OP_S2B,
        OP_DEN,
        OP_U,
        OP_M3A,
        OP_M3B,
        OP_M3C
    } op_t;

    localparam int OUT_W = 32;
    localparam int FRAC_BITS = 32;
    localparam int WLEN_W = 9;
    localparam int MIN_WINDOW = 3;
    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 9'd10;
    localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

@@ src/rolling_window_skewness.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_window_skewness
// Sliding window population skewness in signed Q16.16 over offset samples.
// One item is in work at a time, and a result stalled on the result side
// holds the block in its output state. The single shared adder runs the
// shift-add products, a 42-step square root and a 113-step restoring
// division (WINDOW_MAX = 256, SAMPLE_BITS = 16).
// Reset is synchronous and active low; it clears the window and sums and sets
// the length to 10.
// ----------------------------------------------------------------------------
module rolling_window_skewness #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // sample
    input  logic                        s_tuser,   // restart
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rws_pkg::OUT_W-1:0]   m_tdata,   // skewness
    output logic                        m_tuser,   // valid_res
    input  logic                        cfg_we,
    input  logic [rws_pkg::WLEN_W-1:0]  cfg_wdata
);
    import rws_pkg::*;

    localparam int LW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NW   = $clog2(WINDOW_MAX + 1);
    localparam int DW   = SAMPLE_BITS + 1;
    localparam int MW   = DW - 1;
    localparam int S1W  = DW + LW + 1;
    localparam int S1M  = S1W - 1;
    localparam int S2W  = 2 * DW + LW + 1;
    localparam int S3W  = 3 * DW + LW + 1;
    localparam int DSW  = 2 * MW;
    localparam int QW   = 2 * S1M;
    localparam int UW   = S2W - 1 + S1M;
    localparam int NNW  = 2 * NW;
    localparam int N3W  = NW + 2;
    localparam int M3W  = S1W + S2W + NW + 4;
    localparam int SPW  = NW + S2W - 1;
    localparam int RW   = 2 * ((SPW + FRAC_BITS + 1) / 2);
    localparam int RTW  = RW / 2;
    localparam int DDW  = SPW + RTW;
    localparam int AW   = (DDW + 3 > M3W + 1) ? DDW + 3 : M3W + 1;
    localparam int NUMW = M3W - 1 + FRAC_BITS;
    localparam int SHW  = (NUMW > RW) ? NUMW : RW;
    localparam int BW0  = (RTW > NNW) ? RTW : NNW;
    localparam int BW   = (BW0 > S1W) ? BW0 : S1W;
    localparam int CW   = $clog2(SHW + 1);
    localparam int CMPW = (NW > WLEN_W) ? NW : WLEN_W;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [WLEN_W-1:0]       wl_reg;
    logic                    held_reg;
    logic [NW-1:0]           fill_reg;
    logic [LW-1:0]           wp_reg;
    logic                    full_reg;
    logic signed [SAMPLE_BITS-1:0] ref_reg;
    logic signed [S1W-1:0]   sum1_reg;
    logic signed [S2W-1:0]   sum2_reg;
    logic signed [S3W-1:0]   sum3_reg;
    logic signed [DW-1:0]    d_reg;
    logic signed [DW-1:0]    o_reg;
    logic [DSW-1:0]          dsq_reg;
    logic [DSW-1:0]          osq_reg;
    logic [QW-1:0]           q_reg;
    logic [NNW-1:0]          nn_reg;
    logic [SPW-1:0]          s2_reg;
    logic [DDW-1:0]          den_reg;
    logic [UW-1:0]           u_reg;
    logic                    neg_reg;
    logic [AW-1:0]           acc_reg;
    logic [AW-1:0]           a_reg;
    logic [BW-1:0]           b_reg;
    logic                    sub_reg;
    logic [SHW-1:0]          nsh_reg;
    logic [CW-1:0]           cnt_reg;
    logic [OUT_W-1:0]        quo_reg;
    logic                    ovf_reg;
    logic [OUT_W-1:0]        res_reg;
    logic                    resv_reg;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic                    m_tuser_reg;

    logic signed [DW-1:0]    ring_mem [WINDOW_MAX];
    logic signed [DW-1:0]    rd_q;

    logic [CMPW-1:0]         wl_ext;
    logic [NW-1:0]           n_val;
    logic [N3W-1:0]          n3_val;
    logic signed [SAMPLE_BITS-1:0] samp_raw;
    logic signed [SAMPLE_BITS-1:0] ref_eff;
    logic signed [DW-1:0]    d_in;
    logic                    clr_in;
    logic [NW-1:0]           fill_eff;
    logic [LW-1:0]           wp_eff;
    logic [LW-1:0]           wp_inc;
    logic                    full_eff;
    logic                    full_after;
    logic [MW-1:0]           d_mag;
    logic [MW-1:0]           o_mag;
    logic [S1M-1:0]          s1_mag;
    logic                    s1_neg;
    logic                    s2_nonpos;
    logic                    mul_done;
    logic                    big_q;
    logic [M3W-2:0]          m3_mag;

    logic [AW-1:0]           load_a;
    logic [BW-1:0]           load_b;
    logic                    load_sub;
    logic                    load_clr;
    logic                    load_s3;

    logic [AW-1:0]           alu_x;
    logic [AW-1:0]           alu_y;
    logic                    alu_sub;
    logic [AW-1:0]           alu_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        wl_ext = CMPW'(wl_reg);
        if (wl_ext < CMPW'(MIN_WINDOW)) begin
            n_val = NW'(MIN_WINDOW);
        end else if (wl_ext > CMPW'(WINDOW_MAX)) begin
            n_val = NW'(WINDOW_MAX);
        end else begin
            n_val = NW'(wl_ext);
        end
    end

    assign n3_val   = N3W'({n_val, 1'b0}) + N3W'(n_val);
    assign samp_raw = s_tdata[SAMPLE_BITS-1:0];
    assign clr_in   = s_tuser || !held_reg;
    assign ref_eff  = clr_in ? samp_raw : ref_reg;
    assign d_in     = DW'(samp_raw) - DW'(ref_eff);
    assign fill_eff = clr_in ? '0 : fill_reg;
    assign wp_eff   = (clr_in || (NW'(wp_reg) >= n_val)) ? '0 : wp_reg;
    assign full_eff = (fill_eff >= n_val);
    assign wp_inc   = ((NW'(wp_reg) + NW'(1)) >= n_val) ? '0 : wp_reg + LW'(1);
    assign full_after = full_reg || ((NW + 1)'(fill_reg) + (NW + 1)'(1) >= (NW + 1)'(n_val));

    assign d_mag  = d_reg[DW-1] ? MW'(-d_reg) : MW'(d_reg);
    assign o_mag  = o_reg[DW-1] ? MW'(-o_reg) : MW'(o_reg);
    assign s1_neg = sum1_reg[S1W-1];
    assign s1_mag = s1_neg ? S1M'(-sum1_reg) : S1M'(sum1_reg);
    assign s2_nonpos = acc_reg[AW-1] || (acc_reg == '0);
    assign mul_done  = (b_reg == '0);
    assign big_q     = ovf_reg || quo_reg[OUT_W-1];
    assign m3_mag    = neg_reg ? alu_res[M3W-2:0] : acc_reg[M3W-2:0];

    always_comb begin
        load_a   = '0;
        load_b   = '0;
        load_sub = 1'b0;
        load_clr = 1'b1;
        load_s3  = 1'b0;
        case (op_reg)
            OP_D2: begin
                load_a = AW'(d_mag);
                load_b = BW'(d_mag);
            end
            OP_O2: begin
                load_a = AW'(o_mag);
                load_b = BW'(o_mag);
            end
            OP_D3: begin
                load_a   = AW'(dsq_reg);
                load_b   = BW'(d_mag);
                load_sub = d_reg[DW-1];
                load_clr = 1'b0;
                load_s3  = 1'b1;
            end
            OP_O3: begin
                load_a   = AW'(osq_reg);
                load_b   = BW'(o_mag);
                load_sub = !o_reg[DW-1];
                load_clr = 1'b0;
            end
            OP_Q: begin
                load_a = AW'(s1_mag);
                load_b = BW'(s1_mag);
            end
            OP_NN: begin
                load_a = AW'(n_val);
                load_b = BW'(n_val);
            end
            OP_S2A: begin
                load_a = AW'(sum2_reg);
                load_b = BW'(n_val);
            end
            OP_S2B: begin
                load_a   = AW'(q_reg);
                load_b   = BW'(1);
                load_sub = 1'b1;
                load_clr = 1'b0;
            end
            OP_DEN: begin
                load_a = AW'(s2_reg);
                load_b = BW'(b_reg[RTW-1:0]);
            end
            OP_U: begin
                load_a = AW'(sum2_reg);
                load_b = BW'(s1_mag);
            end
            OP_M3A: begin
                load_a = AW'(sum3_reg);
                load_b = BW'(nn_reg);
            end
            OP_M3B: begin
                load_a   = AW'(u_reg);
                load_b   = BW'(n3_val);
                load_sub = !s1_neg;
                load_clr = 1'b0;
            end
            OP_M3C: begin
                load_a   = AW'({q_reg, 1'b0});
                load_b   = BW'(s1_mag);
                load_sub = s1_neg;
                load_clr = 1'b0;
            end
            default: begin
                load_a = '0;
            end
        endcase
    end

    always_comb begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_MUL: begin
                alu_x   = acc_reg;
                alu_y   = a_reg;
                alu_sub = sub_reg;
            end
            ST_ABS: begin
                alu_y   = acc_reg;
                alu_sub = 1'b1;
            end
            ST_SQRT: begin
                alu_x   = {acc_reg[AW-3:0], nsh_reg[SHW-1 -: 2]};
                alu_y   = AW'({b_reg, 2'b01});
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_x   = {acc_reg[AW-2:0], nsh_reg[SHW-1]};
                alu_y   = AW'(den_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_x + (alu_y ^ {AW{alu_sub}}) + AW'(alu_sub);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_D2;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
                op_next    = OP_D2;
            end
            ST_LOAD: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_LOAD;
                    case (op_reg)
                        OP_D2:  op_next = OP_O2;
                        OP_O2:  op_next = OP_D3;
                        OP_D3:  op_next = OP_O3;
                        OP_O3: begin
                            if (full_after) begin
                                op_next = OP_Q;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        OP_Q:   op_next = OP_NN;
                        OP_NN:  op_next = OP_S2A;
                        OP_S2A: op_next = OP_S2B;
                        OP_S2B: begin
                            state_next = s2_nonpos ? ST_OUT : ST_SQRT;
                        end
                        OP_DEN: op_next = OP_U;
                        OP_U:   op_next = OP_M3A;
                        OP_M3A: op_next = OP_M3B;
                        OP_M3B: op_next = OP_M3C;
                        OP_M3C: state_next = ST_ABS;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SQRT: begin
                if (cnt_reg == '0) begin
                    state_next = ST_LOAD;
                    op_next    = OP_DEN;
                end
            end
            ST_ABS: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg       <= WINDOW_LEN_RESET;
            held_reg     <= 1'b0;
            fill_reg     <= '0;
            wp_reg       <= '0;
            ref_reg      <= '0;
            sum1_reg     <= '0;
            sum2_reg     <= '0;
            sum3_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (clr_in) begin
                            held_reg <= 1'b1;
                            ref_reg  <= samp_raw;
                            sum1_reg <= '0;
                            sum2_reg <= '0;
                            sum3_reg <= '0;
                        end
                        fill_reg <= fill_eff;
                        wp_reg   <= wp_eff;
                        full_reg <= full_eff;
                        d_reg    <= d_in;
                    end
                end
                ST_READ: begin
                    o_reg <= full_reg ? rd_q : '0;
                end
                ST_LOAD: begin
                    a_reg   <= load_a;
                    b_reg   <= load_b;
                    sub_reg <= load_sub;
                    if (load_clr) begin
                        acc_reg <= '0;
                    end else if (load_s3) begin
                        acc_reg <= AW'(sum3_reg);
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        case (op_reg)
                            OP_D2: dsq_reg <= acc_reg[DSW-1:0];
                            OP_O2: osq_reg <= acc_reg[DSW-1:0];
                            OP_O3: begin
                                sum3_reg <= acc_reg[S3W-1:0];
                                sum2_reg <= sum2_reg + S2W'(dsq_reg) - S2W'(osq_reg);
                                sum1_reg <= sum1_reg + S1W'(d_reg) - S1W'(o_reg);
                                fill_reg <= full_reg ? fill_reg : fill_reg + NW'(1);
                                wp_reg   <= wp_inc;
                                res_reg  <= '0;
                                resv_reg <= 1'b0;
                            end
                            OP_Q:  q_reg  <= acc_reg[QW-1:0];
                            OP_NN: nn_reg <= acc_reg[NNW-1:0];
                            OP_S2B: begin
                                res_reg  <= '0;
                                resv_reg <= 1'b1;
                                s2_reg   <= acc_reg[SPW-1:0];
                                nsh_reg  <= SHW'(acc_reg[SPW-1:0]) << (SHW - RW + FRAC_BITS);
                                acc_reg  <= '0;
                                b_reg    <= '0;
                                cnt_reg  <= CW'(RTW);
                            end
                            OP_DEN: den_reg <= acc_reg[DDW-1:0];
                            OP_U:   u_reg   <= acc_reg[UW-1:0];
                            OP_M3C: neg_reg <= acc_reg[AW-1];
                            default: begin
                                neg_reg <= neg_reg;
                            end
                        endcase
                    end else begin
                        if (b_reg[0]) begin
                            acc_reg <= alu_res;
                        end
                        a_reg <= a_reg << 1;
                        b_reg <= b_reg >> 1;
                    end
                end
                ST_SQRT: begin
                    if (cnt_reg != '0) begin
                        if (!alu_res[AW-1]) begin
                            acc_reg <= alu_res;
                            b_reg   <= {b_reg[BW-2:0], 1'b1};
                        end else begin
                            acc_reg <= alu_x;
                            b_reg   <= {b_reg[BW-2:0], 1'b0};
                        end
                        nsh_reg <= nsh_reg << 2;
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                ST_ABS: begin
                    nsh_reg <= SHW'(m3_mag) << (SHW - NUMW + FRAC_BITS);
                    acc_reg <= '0;
                    quo_reg <= '0;
                    ovf_reg <= 1'b0;
                    cnt_reg <= CW'(NUMW);
                end
                ST_DIV: begin
                    if (cnt_reg != '0) begin
                        acc_reg <= alu_res[AW-1] ? alu_x : alu_res;
                        ovf_reg <= ovf_reg | quo_reg[OUT_W-1];
                        quo_reg <= {quo_reg[OUT_W-2:0], !alu_res[AW-1]};
                        nsh_reg <= nsh_reg << 1;
                        cnt_reg <= cnt_reg - CW'(1);
                    end else begin
                        resv_reg <= 1'b1;
                        if (neg_reg) begin
                            res_reg <= big_q ? SAT_NEG : -quo_reg;
                        end else begin
                            res_reg <= big_q ? SAT_POS : quo_reg;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        m_tuser_reg  <= resv_reg;
                    end
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
            if (cfg_we) begin
                wl_reg   <= cfg_wdata;
                held_reg <= 1'b0;
                fill_reg <= '0;
                wp_reg   <= '0;
                ref_reg  <= '0;
                sum1_reg <= '0;
                sum2_reg <= '0;
                sum3_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL && op_reg == OP_O3 && mul_done) begin
            ring_mem[wp_reg] <= d_reg;
        end
        if (state_reg == ST_IDLE && s_tvalid) begin
            rd_q <= ring_mem[wp_eff];
        end
    end

endmodule

@@ src/rws_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_checker
// Port-level checks for the rolling window skewness block.
// ----------------------------------------------------------------------------
module rws_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rws_pkg::OUT_W-1:0] m_tdata,
    input logic                      m_tuser
);
    import rws_pkg::*;

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item still in work");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_not_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("nonzero skewness with window not full");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

endmodule

bind rolling_window_skewness rws_checker u_rws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
